// ===== hdl/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants of the flap clock stepper sync controller.
// ----------------------------------------------------------------------------
package fcs_pkg;

	// command codes carried in s_tuser
	typedef enum logic [3:0] {
		OP_TICK        = 4'd0,
		OP_SET_HOUR    = 4'd1,
		OP_SET_MINUTE  = 4'd2,
		OP_SET_BOTH    = 4'd3,
		OP_FIND_HOUR   = 4'd4,
		OP_FIND_MINUTE = 4'd5,
		OP_CAL_HOUR    = 4'd6,
		OP_CAL_MINUTE  = 4'd7,
		OP_STOP        = 4'd8,
		OP_RUN         = 4'd9
	} fcs_op_t;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_CAL_HOUR       = 3'd0;
	localparam logic [2:0] REG_CAL_MINUTE     = 3'd1;
	localparam logic [2:0] REG_DELAY_HOUR     = 3'd2;
	localparam logic [2:0] REG_DELAY_MINUTE   = 3'd3;
	localparam logic [2:0] REG_DIVIDER_HOUR   = 3'd4;
	localparam logic [2:0] REG_DIVIDER_MINUTE = 3'd5;

	localparam logic [6:0] HOUR_WRAP   = 7'd23;
	localparam logic [6:0] MINUTE_WRAP = 7'd59;

	localparam logic [7:0] DIVIDER_HOUR_RST   = 8'd3;
	localparam logic [7:0] DIVIDER_MINUTE_RST = 8'd10;

	// mode codes as reported in the result
	localparam logic [2:0] MODE_CODE_STOP        = 3'd0;
	localparam logic [2:0] MODE_CODE_RUN         = 3'd1;
	localparam logic [2:0] MODE_CODE_FIND_HOUR   = 3'd2;
	localparam logic [2:0] MODE_CODE_DELAY_HOUR  = 3'd3;
	localparam logic [2:0] MODE_CODE_FIND_MINUTE = 3'd4;
	localparam logic [2:0] MODE_CODE_DELAY_MINUTE = 3'd5;

	typedef enum logic [5:0] {
		MODE_STOP         = 6'b000001,
		MODE_RUN          = 6'b000010,
		MODE_FIND_HOUR    = 6'b000100,
		MODE_DELAY_HOUR   = 6'b001000,
		MODE_FIND_MINUTE  = 6'b010000,
		MODE_DELAY_MINUTE = 6'b100000
	} fcs_mode_t;

	typedef struct packed {
		logic [6:0] cal_hour;
		logic [6:0] cal_minute;
		logic [6:0] delay_hour;
		logic [6:0] delay_minute;
		logic [7:0] divider_hour;
		logic [7:0] divider_minute;
	} fcs_cfg_t;

	// per-channel controls for one accepted transaction
	typedef struct packed {
		logic run;
		logic find;
		logic delay;
		logic cal;
		logic set_goal;
	} fcs_chan_ctl_t;

	// per-channel result of one accepted transaction
	typedef struct packed {
		logic        step;
		logic        stop;
		logic        rep;
		logic [15:0] steps;
		logic [6:0]  pos;
		logic        home_hit;
		logic        delay_done;
	} fcs_chan_res_t;

	function automatic logic [2:0] mode_code(fcs_mode_t m);
		logic [2:0] c;
		case (m)
			MODE_STOP:         c = MODE_CODE_STOP;
			MODE_RUN:          c = MODE_CODE_RUN;
			MODE_FIND_HOUR:    c = MODE_CODE_FIND_HOUR;
			MODE_DELAY_HOUR:   c = MODE_CODE_DELAY_HOUR;
			MODE_FIND_MINUTE:  c = MODE_CODE_FIND_MINUTE;
			MODE_DELAY_MINUTE: c = MODE_CODE_DELAY_MINUTE;
			default:           c = MODE_CODE_STOP;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/fcs_regs.sv =====
// ----------------------------------------------------------------------------
// fcs_regs
// APB configuration registers: calibration, home delay and step divider.
// ----------------------------------------------------------------------------
module fcs_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output fcs_pkg::fcs_cfg_t   cfg
);
	import fcs_pkg::*;

	fcs_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_hour       <= '0;
			cfg_q.cal_minute     <= '0;
			cfg_q.delay_hour     <= '0;
			cfg_q.delay_minute   <= '0;
			cfg_q.divider_hour   <= DIVIDER_HOUR_RST;
			cfg_q.divider_minute <= DIVIDER_MINUTE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CAL_HOUR:       cfg_q.cal_hour       <= pwdata[6:0];
				REG_CAL_MINUTE:     cfg_q.cal_minute     <= pwdata[6:0];
				REG_DELAY_HOUR:     cfg_q.delay_hour     <= pwdata[6:0];
				REG_DELAY_MINUTE:   cfg_q.delay_minute   <= pwdata[6:0];
				REG_DIVIDER_HOUR:   cfg_q.divider_hour   <= pwdata[7:0];
				REG_DIVIDER_MINUTE: cfg_q.divider_minute <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CAL_HOUR:       prdata = {25'd0, cfg_q.cal_hour};
			REG_CAL_MINUTE:     prdata = {25'd0, cfg_q.cal_minute};
			REG_DELAY_HOUR:     prdata = {25'd0, cfg_q.delay_hour};
			REG_DELAY_MINUTE:   prdata = {25'd0, cfg_q.delay_minute};
			REG_DIVIDER_HOUR:   prdata = {24'd0, cfg_q.divider_hour};
			REG_DIVIDER_MINUTE: prdata = {24'd0, cfg_q.divider_minute};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/fcs_channel.sv =====
// ----------------------------------------------------------------------------
// fcs_channel
// State and next-state logic of one motor channel (position, goal, divider,
// home delay, sync flag, step tally), updated once per accepted transaction.
// ----------------------------------------------------------------------------
module fcs_channel (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  fcs_pkg::fcs_chan_ctl_t ctl,
	input  logic [6:0]             goal_in,
	input  logic                   home,
	input  logic                   flap,
	input  logic [6:0]             cal,
	input  logic [6:0]             dly,
	input  logic [7:0]             divider,
	input  logic [6:0]             wrap,
	output fcs_pkg::fcs_chan_res_t res
);
	import fcs_pkg::*;

	logic [6:0]  pos_q, goal_q, n_pos, n_goal;
	logic [7:0]  cnt_q, hdel_q, n_cnt, n_hdel, hd_run;
	logic        synced_q, n_synced;
	logic [15:0] tally_q, n_tally;
	logic        div_req;

	always_comb begin
		n_pos    = pos_q;
		n_goal   = goal_q;
		n_cnt    = cnt_q;
		n_hdel   = hdel_q;
		n_synced = synced_q;
		n_tally  = tally_q;
		div_req  = 1'b0;
		res      = '0;
		hd_run   = home ? 8'd1 : hdel_q;

		if (ctl.run) begin
			n_hdel = hd_run;
			if (hd_run != 8'd0) begin
				n_hdel = hd_run + 8'd1;
				if (hd_run > {1'b0, dly}) begin
					n_pos    = cal;
					n_synced = 1'b1;
					n_hdel   = 8'd0;
				end
			end
			if (flap) begin
				if (n_synced)
					n_pos = n_pos + 7'd1;
				if (n_pos > wrap)
					n_pos = 7'd0;
				res.rep   = 1'b1;
				res.steps = tally_q;
				n_tally   = 16'd0;
			end
			if (n_pos != goal_q)
				div_req = 1'b1;
			else
				res.stop = 1'b1;
		end else if (ctl.find) begin
			if (!home) begin
				div_req = 1'b1;
			end else begin
				n_hdel       = 8'd1;
				res.home_hit = 1'b1;
			end
		end else if (ctl.delay) begin
			if (hdel_q != 8'd0) begin
				n_hdel = hdel_q + 8'd1;
				if (hdel_q > {1'b0, dly}) begin
					res.stop       = 1'b1;
					res.delay_done = 1'b1;
					n_hdel         = 8'd0;
					n_pos          = cal;
				end else begin
					res.step = 1'b1;
					n_tally  = tally_q + 16'd1;
				end
			end
		end

		// divided stepping
		if (div_req) begin
			n_cnt = cnt_q + 8'd1;
			if (cnt_q >= divider) begin
				n_cnt    = 8'd0;
				res.step = 1'b1;
				n_tally  = n_tally + 16'd1;
			end
		end

		// in find and delay modes the flap report follows the step
		if ((ctl.find || ctl.delay) && flap) begin
			res.rep   = 1'b1;
			res.steps = n_tally;
			n_tally   = 16'd0;
		end

		if (ctl.cal) begin
			n_pos  = cal;
			n_goal = cal;
		end
		if (ctl.set_goal)
			n_goal = goal_in;

		res.pos = n_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 7'd1;
			goal_q   <= 7'd0;
			cnt_q    <= 8'd0;
			hdel_q   <= 8'd0;
			synced_q <= 1'b0;
			tally_q  <= 16'd0;
		end else if (en) begin
			pos_q    <= n_pos;
			goal_q   <= n_goal;
			cnt_q    <= n_cnt;
			hdel_q   <= n_hdel;
			synced_q <= n_synced;
			tally_q  <= n_tally;
		end
	end

endmodule

// ===== hdl/flap_clock_stepper_sync_controller_top.sv =====
// ----------------------------------------------------------------------------
// flap_clock_stepper_sync_controller_top
// Hour and minute stepper control of a flap clock, one tick or command per
// transaction.
// ----------------------------------------------------------------------------
// Takes one tick or decoded command per clock cycle unless the output stalls,
// and returns exactly one result per transaction in the cycle after it is
// accepted. The whole update of both channels and the mode is a single
// combinational pass from the channel state registers into the output
// register; the output register acts as the skid stage, so s_tready stays high
// while the result is taken in the same cycle. The user makes configuration
// writes through the APB port only while idle; the block does not enforce it.
module flap_clock_stepper_sync_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] target_hour, [13:7] target_minute, [14] home_hour,
	// [15] home_minute, [16] flap_hour, [17] flap_minute, [23:18] zero
	input  logic [23:0] s_tdata,
	// [3:0] opcode
	input  logic [3:0]  s_tuser,
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] step_hour, [1] stop_hour, [2] step_minute, [3] stop_minute,
	// [10:4] shown_hour, [17:11] shown_minute, [20:18] mode,
	// [21] report_hour, [37:22] steps_hour, [38] report_minute,
	// [54:39] steps_minute, [55] zero
	output logic [55:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fcs_pkg::*;

	fcs_cfg_t      cfg;
	fcs_chan_ctl_t ctl_h, ctl_m;
	fcs_chan_res_t res_h, res_m;
	fcs_mode_t     mode_q, mode_next;
	fcs_op_t       op;
	logic          accept, tick;
	logic          m_tvalid_q;
	logic [55:0]   m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = fcs_op_t'(s_tuser);
	assign tick     = (op == OP_TICK);

	assign ctl_h.run      = tick && (mode_q == MODE_RUN);
	assign ctl_h.find     = tick && (mode_q == MODE_FIND_HOUR);
	assign ctl_h.delay    = tick && (mode_q == MODE_DELAY_HOUR);
	assign ctl_h.cal      = (op == OP_CAL_HOUR);
	assign ctl_h.set_goal = (op == OP_SET_HOUR) || (op == OP_SET_BOTH);

	assign ctl_m.run      = tick && (mode_q == MODE_RUN);
	assign ctl_m.find     = tick && (mode_q == MODE_FIND_MINUTE);
	assign ctl_m.delay    = tick && (mode_q == MODE_DELAY_MINUTE);
	assign ctl_m.cal      = (op == OP_CAL_MINUTE);
	assign ctl_m.set_goal = (op == OP_SET_MINUTE) || (op == OP_SET_BOTH);

	fcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fcs_channel u_hour (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.ctl     (ctl_h),
		.goal_in (s_tdata[6:0]),
		.home    (s_tdata[14]),
		.flap    (s_tdata[16]),
		.cal     (cfg.cal_hour),
		.dly     (cfg.delay_hour),
		.divider (cfg.divider_hour),
		.wrap    (HOUR_WRAP),
		.res     (res_h)
	);

	fcs_channel u_minute (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.ctl     (ctl_m),
		.goal_in (s_tdata[13:7]),
		.home    (s_tdata[15]),
		.flap    (s_tdata[17]),
		.cal     (cfg.cal_minute),
		.dly     (cfg.delay_minute),
		.divider (cfg.divider_minute),
		.wrap    (MINUTE_WRAP),
		.res     (res_m)
	);

	always_comb begin
		mode_next = mode_q;
		case (op)
			OP_TICK: begin
				if (res_h.home_hit)
					mode_next = MODE_DELAY_HOUR;
				else if (res_m.home_hit)
					mode_next = MODE_DELAY_MINUTE;
				else if (res_h.delay_done || res_m.delay_done)
					mode_next = MODE_RUN;
			end
			OP_FIND_HOUR:   mode_next = MODE_FIND_HOUR;
			OP_FIND_MINUTE: mode_next = MODE_FIND_MINUTE;
			OP_CAL_HOUR, OP_CAL_MINUTE, OP_RUN: mode_next = MODE_RUN;
			OP_STOP:        mode_next = MODE_STOP;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RUN;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept)
				mode_q <= mode_next;
			if (accept)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, res_m.steps, res_m.rep, res_h.steps, res_h.rep,
				mode_code(mode_next), res_m.pos, res_h.pos,
				res_m.stop, res_m.step, res_h.stop, res_h.step};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/fcs_checker.sv =====
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);
	import fcs_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted transaction shows a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction without result");

	// commands never step, stop or report
	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != OP_TICK)
		|=> (m_tdata[3:0] == 4'd0) && !m_tdata[21] && !m_tdata[38])
		else $error("command transaction drove motor or report");

	// a channel never steps and stops together
	a_step_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !(m_tdata[2] && m_tdata[3]))
		else $error("step and stop on one channel");

	// step counts are zero without a report
	a_steps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[21] || (m_tdata[37:22] == 16'd0))
			&& (m_tdata[38] || (m_tdata[54:39] == 16'd0)))
		else $error("step count without report");

endmodule

bind flap_clock_stepper_sync_controller_top fcs_checker u_fcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flap clock stepper sync controller. A scoreboard
// class carries its own model of both motor channels and the mode, predicts
// one motor result per accepted transaction, and compares every output field.
// Directed ticks and commands come first, then phases of random traffic, each
// under its own register setting, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
	import fcs_pkg::*;

	class flap_scoreboard;
		// register copies, index 0 = hour channel, 1 = minute channel
		bit [6:0]  cal[2];
		bit [6:0]  dly[2];
		bit [7:0]  divr[2];
		// channel state
		bit [2:0]  mode;
		bit [6:0]  pos[2];
		bit [6:0]  goal[2];
		bit [7:0]  div_cnt[2];
		bit [7:0]  home_cnt[2];
		bit        synced[2];
		bit [15:0] tally[2];
		// per-transaction outputs
		bit        o_step[2];
		bit        o_stop[2];
		bit        o_rep[2];
		bit [15:0] o_steps[2];

		bit [55:0] motor_results[$];
		int        failures;
		int        results_seen;

		function new();
			cal = '{7'd0, 7'd0};
			dly = '{7'd0, 7'd0};
			divr = '{DIVIDER_HOUR_RST, DIVIDER_MINUTE_RST};
			mode = MODE_CODE_RUN;
			pos = '{7'd1, 7'd1};
			goal = '{7'd0, 7'd0};
			div_cnt = '{8'd0, 8'd0};
			home_cnt = '{8'd0, 8'd0};
			synced = '{1'b0, 1'b0};
			tally = '{16'd0, 16'd0};
			failures = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_CAL_HOUR:       cal[0] = v[6:0];
				REG_CAL_MINUTE:     cal[1] = v[6:0];
				REG_DELAY_HOUR:     dly[0] = v[6:0];
				REG_DELAY_MINUTE:   dly[1] = v[6:0];
				REG_DIVIDER_HOUR:   divr[0] = v[7:0];
				REG_DIVIDER_MINUTE: divr[1] = v[7:0];
				default: ;
			endcase
		endfunction

		function bit divided_step(int c);
			bit [7:0] old;
			old = div_cnt[c];
			div_cnt[c] = old + 8'd1;
			if (old >= divr[c]) begin
				div_cnt[c] = 8'd0;
				tally[c] = tally[c] + 16'd1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void flap_seen(int c);
			o_rep[c] = 1'b1;
			o_steps[c] = tally[c];
			tally[c] = 16'd0;
		endfunction

		function void run_tick(int c, bit home, bit flap);
			bit [7:0] old;
			if (home)
				home_cnt[c] = 8'd1;
			if (home_cnt[c] != 8'd0) begin
				old = home_cnt[c];
				home_cnt[c] = old + 8'd1;
				if (old > dly[c]) begin
					pos[c] = cal[c];
					synced[c] = 1'b1;
					home_cnt[c] = 8'd0;
				end
			end
			if (flap) begin
				if (synced[c])
					pos[c] = pos[c] + 7'd1;
				if (pos[c] > ((c == 0) ? HOUR_WRAP : MINUTE_WRAP))
					pos[c] = 7'd0;
				flap_seen(c);
			end
			if (pos[c] != goal[c])
				o_step[c] = divided_step(c);
			else
				o_stop[c] = 1'b1;
		endfunction

		function void find_tick(int c, bit home, bit flap);
			if (!home) begin
				o_step[c] = divided_step(c);
			end else begin
				home_cnt[c] = 8'd1;
				mode = (c == 0) ? MODE_CODE_DELAY_HOUR : MODE_CODE_DELAY_MINUTE;
			end
			if (flap)
				flap_seen(c);
		endfunction

		// steps once per tick after home; back to run when the delay is over
		function void delay_tick(int c, bit flap);
			bit [7:0] old;
			if (home_cnt[c] != 8'd0) begin
				old = home_cnt[c];
				home_cnt[c] = old + 8'd1;
				if (old > dly[c]) begin
					o_stop[c] = 1'b1;
					home_cnt[c] = 8'd0;
					pos[c] = cal[c];
					mode = MODE_CODE_RUN;
				end else begin
					o_step[c] = 1'b1;
					tally[c] = tally[c] + 16'd1;
				end
			end
			if (flap)
				flap_seen(c);
		endfunction

		function void apply_item(logic [3:0] op, logic [6:0] th, logic [6:0] tm,
				logic hh, logic hm, logic fh, logic fm);
			for (int c = 0; c < 2; c++) begin
				o_step[c] = 1'b0;
				o_stop[c] = 1'b0;
				o_rep[c] = 1'b0;
				o_steps[c] = 16'd0;
			end
			case (op)
				OP_TICK: begin
					case (mode)
						MODE_CODE_RUN: begin
							run_tick(0, hh, fh);
							run_tick(1, hm, fm);
						end
						MODE_CODE_FIND_HOUR:    find_tick(0, hh, fh);
						MODE_CODE_FIND_MINUTE:  find_tick(1, hm, fm);
						MODE_CODE_DELAY_HOUR:   delay_tick(0, fh);
						MODE_CODE_DELAY_MINUTE: delay_tick(1, fm);
						default: ;
					endcase
				end
				OP_SET_HOUR:   goal[0] = th;
				OP_SET_MINUTE: goal[1] = tm;
				OP_SET_BOTH: begin
					goal[0] = th;
					goal[1] = tm;
				end
				OP_FIND_HOUR:   mode = MODE_CODE_FIND_HOUR;
				OP_FIND_MINUTE: mode = MODE_CODE_FIND_MINUTE;
				OP_CAL_HOUR: begin
					pos[0] = cal[0];
					goal[0] = cal[0];
					mode = MODE_CODE_RUN;
				end
				OP_CAL_MINUTE: begin
					pos[1] = cal[1];
					goal[1] = cal[1];
					mode = MODE_CODE_RUN;
				end
				OP_STOP: mode = MODE_CODE_STOP;
				OP_RUN:  mode = MODE_CODE_RUN;
				default: ;
			endcase
			motor_results.push_back({1'b0, o_steps[1], o_rep[1], o_steps[0], o_rep[0],
				mode, pos[1], pos[0], o_stop[1], o_step[1], o_stop[0], o_step[0]});
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_motor_result(bit [55:0] got);
			int        lsb[11] = '{0, 1, 2, 3, 4, 11, 18, 21, 22, 38, 39};
			int        wid[11] = '{1, 1, 1, 1, 7, 7, 3, 1, 16, 1, 16};
			string     nm[11] = '{"step_hour", "stop_hour", "step_minute", "stop_minute",
				"shown_hour", "shown_minute", "mode", "report_hour", "steps_hour",
				"report_minute", "steps_minute"};
			bit [55:0] want;
			bit [15:0] w;
			bit [15:0] g;
			results_seen++;
			if (motor_results.size() == 0) begin
				note_failure($sformatf("result %0d with nothing expected: %h",
					results_seen, got));
				return;
			end
			want = motor_results.pop_front();
			for (int i = 0; i < 11; i++) begin
				w = 16'((want >> lsb[i]) & ((56'd1 << wid[i]) - 56'd1));
				g = 16'((got >> lsb[i]) & ((56'd1 << wid[i]) - 56'd1));
				if (w != g)
					note_failure($sformatf("result %0d %s expected %0d got %0d",
						results_seen, nm[i], w, g));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic           hold_req = 1'b0;
	int             burst_left = 0;
	flap_scoreboard sb = new();

	flap_clock_stepper_sync_controller_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_motor_result(m_tdata);
	end

	// receiver: rotating stall pattern, plus a long hold-off on request
	initial begin
		logic [15:0] pat;
		int          ph;
		int          hold_left;
		pat = 16'hFFFF;
		ph = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				hold_left = 64;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= pat[ph];
				ph++;
				if (ph == 16) begin
					ph = 0;
					case ($urandom_range(0, 3))
						0: pat = 16'hFFFF;
						1: pat = 16'($urandom) | 16'h8000;
						2: pat = 16'($urandom | $urandom);
						default: pat = 16'($urandom & $urandom) | 16'h0001;
					endcase
				end
			end
		end
	end

	task automatic offer(logic [3:0] op, logic [6:0] th, logic [6:0] tm,
			logic hh, logic hm, logic fh, logic fm);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, fm, fh, hm, hh, tm, th};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.apply_item(op, th, tm, hh, hm, fh, fm);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.motor_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	// phase 0 all minimum, phase 1 at the random maxima, then random settings
	task automatic program_phase(int ph);
		logic [31:0] cal_h;
		logic [31:0] cal_m;
		logic [31:0] dly_h;
		logic [31:0] dly_m;
		logic [31:0] div_h;
		logic [31:0] div_m;
		cal_h = $urandom_range(0, 99);
		cal_m = $urandom_range(0, 99);
		dly_h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 8);
		dly_m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 8);
		div_h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
		div_m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
		if (ph == 0) begin
			cal_h = 0; cal_m = 0; dly_h = 0; dly_m = 0; div_h = 0; div_m = 0;
		end else if (ph == 1) begin
			cal_h = 99; cal_m = 99; dly_h = 99; dly_m = 99; div_h = 255; div_m = 255;
		end
		apb_write(REG_CAL_HOUR, cal_h);
		apb_write(REG_CAL_MINUTE, cal_m);
		apb_write(REG_DELAY_HOUR, dly_h);
		apb_write(REG_DELAY_MINUTE, dly_m);
		apb_write(REG_DIVIDER_HOUR, div_h);
		apb_write(REG_DIVIDER_MINUTE, div_m);
	endtask

	task automatic random_item();
		logic [3:0] op;
		logic [6:0] th;
		logic [6:0] tm;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 78)
			op = OP_TICK;
		else if (r < 84)
			op = 4'($urandom_range(OP_SET_HOUR, OP_SET_BOTH));
		else if (r < 88)
			op = 4'($urandom_range(OP_FIND_HOUR, OP_FIND_MINUTE));
		else if (r < 91)
			op = 4'($urandom_range(OP_CAL_HOUR, OP_CAL_MINUTE));
		else if (r < 93)
			op = OP_STOP;
		else if (r < 97)
			op = OP_RUN;
		else
			op = 4'($urandom_range(int'(OP_RUN) + 1, 15));
		th = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, 23));
		tm = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
			: 7'($urandom_range(0, 59));
		offer(op, th, tm, $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
			$urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_TICK;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every command, home and flap corners
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_TICK, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(OP_SET_BOTH, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_SET_HOUR, 7'd127, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_SET_MINUTE, 7'd0, 7'd127, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_SET_BOTH, 7'd99, 7'd99, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(OP_TICK, 7'd0, 7'd0, 1'b1, 1'b1, 1'b0, 1'b0);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b1, 1'b1);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b1, 1'b0);
		offer(OP_CAL_HOUR, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_CAL_MINUTE, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_FIND_HOUR, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b1, 1'b0, 1'b0);
		offer(OP_TICK, 7'd0, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_FIND_MINUTE, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b1, 1'b0, 1'b1);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		offer(OP_TICK, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_STOP, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(OP_TICK, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(OP_RUN, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(4'(int'(OP_RUN) + 1), 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(4'hF, 7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(OP_SET_BOTH, HOUR_WRAP, MINUTE_WRAP, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			program_phase(ph);
			for (int k = 0; k < 120; k++) begin
				// long receiver hold-off while input keeps coming
				if ((ph == 2 || ph == 5) && k == 40)
					hold_req <= 1'b1;
				random_item();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.motor_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
